// ----- hw/rtl/u8sc_pkg.sv -----
// u8sc_pkg: shared constants for the UTF-8 string checker.
// Byte range limits, first-continuation bound codes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package u8sc_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned TagW    = 6;
   localparam int unsigned StatusW = 2;
   localparam int unsigned BoundW  = 3;
   localparam int unsigned LeftW   = 2;

   localparam logic [ByteW-1:0] ContLo   = 8'h80;
   localparam logic [ByteW-1:0] ContHi   = 8'hBF;
   localparam logic [ByteW-1:0] Lead2Lo  = 8'hC2;
   localparam logic [ByteW-1:0] Lead2Hi  = 8'hDF;
   localparam logic [ByteW-1:0] Lead3Lo  = 8'hE0;
   localparam logic [ByteW-1:0] Lead3Hi  = 8'hEF;
   localparam logic [ByteW-1:0] Lead3Sur = 8'hED;
   localparam logic [ByteW-1:0] Lead4Lo  = 8'hF0;
   localparam logic [ByteW-1:0] Lead4Hi  = 8'hF4;
   localparam logic [ByteW-1:0] FirstA0  = 8'hA0;
   localparam logic [ByteW-1:0] First9F  = 8'h9F;
   localparam logic [ByteW-1:0] First90  = 8'h90;
   localparam logic [ByteW-1:0] First8F  = 8'h8F;

   localparam logic [BoundW-1:0] BND_FULL   = 3'd0;
   localparam logic [BoundW-1:0] BND_A0_BF  = 3'd1;
   localparam logic [BoundW-1:0] BND_80_9F  = 3'd2;
   localparam logic [BoundW-1:0] BND_90_BF  = 3'd3;
   localparam logic [BoundW-1:0] BND_80_8F  = 3'd4;

   localparam logic [StatusW-1:0] ST_OK        = 2'd0;
   localparam logic [StatusW-1:0] ST_EMPTY_REQ = 2'd1;
   localparam logic [StatusW-1:0] ST_NUL       = 2'd2;
   localparam logic [StatusW-1:0] ST_BAD_UTF8  = 2'd3;

endpackage

// ----- hw/rtl/utf8_string_checker_unit.sv -----
// utf8_string_checker_unit: strict UTF-8 checker over a byte stream, one
// result beat per string. Uses u8sc_pkg.
//
//   channel | dir | payload
//   req     | in  | tdata {field_tag, data_byte}, tuser {required, byte_present}, tlast
//   rsp     | out | tdata {tag_out, status}
//
// One beat per cycle sustained while results are taken. A beat waits in the input
// register until the decode logic updates the string state from it; a result is
// written to the output register as its last beat is decoded.
// Reset clears the valid flags of both registers and all string state.
// A result left untaken stalls decoding only; one more beat is still taken.
`timescale 1ns / 1ps

module utf8_string_checker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [13:8] field_tag, [15:14] zero
   input  logic [1:0]  req_tuser,   // [0] byte_present, [1] required
   input  logic        req_tlast,   // last_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] status, [7:2] tag_out
);
   import u8sc_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [ByteW-1:0]    in_byte_ff;
   logic [TagW-1:0]     in_tag_ff;
   logic                in_present_ff, in_required_ff, in_last_ff;

   logic [LeftW-1:0]    bytes_left_ff, bytes_left_in;
   logic                expect_first_ff, expect_first_in;
   logic [BoundW-1:0]   first_bounds_ff, first_bounds_in;
   logic                bad_utf8_ff, bad_utf8_in;
   logic                saw_nul_ff, saw_nul_in;
   logic                saw_byte_ff, saw_byte_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [StatusW-1:0]  rsp_status_ff, rsp_status_in;
   logic [TagW-1:0]     rsp_tag_ff;

   logic                advance, process, req_accept;
   logic [ByteW-1:0]    lo, hi;
   logic                bad_fin;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept ? 1'b1 : (process ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (process && in_last_ff) ? 1'b1
                       : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      lo = ContLo;
      hi = ContHi;
      if (expect_first_ff) begin
         unique case (first_bounds_ff)
            BND_A0_BF: lo = FirstA0;
            BND_80_9F: hi = First9F;
            BND_90_BF: lo = First90;
            BND_80_8F: hi = First8F;
            default:   ;
         endcase
      end
   end

   always_comb begin
      bytes_left_in   = bytes_left_ff;
      expect_first_in = expect_first_ff;
      first_bounds_in = first_bounds_ff;
      bad_utf8_in     = bad_utf8_ff;
      saw_nul_in      = saw_nul_ff;
      saw_byte_in     = saw_byte_ff;
      rsp_status_in   = ST_OK;
      bad_fin         = 1'b0;
      if (in_present_ff) begin
         saw_byte_in = 1'b1;
         if (in_byte_ff == '0) begin
            saw_nul_in = 1'b1;
         end
         if (bytes_left_ff == '0) begin
            if (in_byte_ff < ContLo) begin
               // ASCII, nothing to track
            end else if (in_byte_ff >= Lead2Lo && in_byte_ff <= Lead2Hi) begin
               bytes_left_in   = 2'd1;
               first_bounds_in = BND_FULL;
               expect_first_in = 1'b1;
            end else if (in_byte_ff >= Lead3Lo && in_byte_ff <= Lead3Hi) begin
               bytes_left_in   = 2'd2;
               first_bounds_in = (in_byte_ff == Lead3Lo)  ? BND_A0_BF
                               : (in_byte_ff == Lead3Sur) ? BND_80_9F : BND_FULL;
               expect_first_in = 1'b1;
            end else if (in_byte_ff >= Lead4Lo && in_byte_ff <= Lead4Hi) begin
               bytes_left_in   = 2'd3;
               first_bounds_in = (in_byte_ff == Lead4Lo) ? BND_90_BF
                               : (in_byte_ff == Lead4Hi) ? BND_80_8F : BND_FULL;
               expect_first_in = 1'b1;
            end else begin
               bad_utf8_in = 1'b1;
            end
         end else if (in_byte_ff < lo || in_byte_ff > hi) begin
            bad_utf8_in     = 1'b1;
            bytes_left_in   = '0;
            expect_first_in = 1'b0;
            first_bounds_in = BND_FULL;
         end else begin
            bytes_left_in   = bytes_left_ff - 2'd1;
            expect_first_in = 1'b0;
            if (bytes_left_ff == 2'd1) begin
               first_bounds_in = BND_FULL;
            end
         end
      end
      if (in_last_ff) begin
         bad_fin = bad_utf8_in || (bytes_left_in != '0);
         if (in_required_ff && !saw_byte_in) begin
            rsp_status_in = ST_EMPTY_REQ;
         end else if (saw_nul_in) begin
            rsp_status_in = ST_NUL;
         end else if (bad_fin) begin
            rsp_status_in = ST_BAD_UTF8;
         end
         bytes_left_in   = '0;
         expect_first_in = 1'b0;
         first_bounds_in = BND_FULL;
         bad_utf8_in     = 1'b0;
         saw_nul_in      = 1'b0;
         saw_byte_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         bytes_left_ff   <= '0;
         expect_first_ff <= 1'b0;
         first_bounds_ff <= BND_FULL;
         bad_utf8_ff     <= 1'b0;
         saw_nul_ff      <= 1'b0;
         saw_byte_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            bytes_left_ff   <= bytes_left_in;
            expect_first_ff <= expect_first_in;
            first_bounds_ff <= first_bounds_in;
            bad_utf8_ff     <= bad_utf8_in;
            saw_nul_ff      <= saw_nul_in;
            saw_byte_ff     <= saw_byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff     <= req_tdata[ByteW-1:0];
         in_tag_ff      <= req_tdata[ByteW+TagW-1:ByteW];
         in_present_ff  <= req_tuser[0];
         in_required_ff <= req_tuser[1];
         in_last_ff     <= req_tlast;
      end
      if (process && in_last_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_tag_ff    <= in_tag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_tag_ff, rsp_status_ff};

endmodule

// ----- hw/rtl/u8sc_checker.sv -----
// u8sc_checker: port-level assertions for utf8_string_checker_unit.
// Bound to utf8_string_checker_unit below; no other dependencies.
`timescale 1ns / 1ps

module u8sc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a result beat never appears straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // input side only backs up behind a stalled result beat
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

endmodule

bind utf8_string_checker_unit u8sc_checker u_u8sc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- dv/utf8_string_checker_unit_test.sv -----
// utf8_string_checker_unit_test: stream testbench for the UTF-8 string checker.
// A directed table, then random strings, each checked against a local decoder or a typed table row.
// Depends on u8sc_pkg and utf8_string_checker_unit.
`timescale 1ns / 1ps

module utf8_string_checker_unit_test;
   import u8sc_pkg::*;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             present;
      logic             last;
      logic             required;
      logic [TagW-1:0]  tag;
   } beat_type;

   typedef struct packed {
      beat_type            b;
      logic                typed;
      logic [StatusW-1:0]  st;
   } row_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [TagW-1:0]    tag;
   } verdict_type;

   localparam logic Y = 1'b1;
   localparam logic N = 1'b0;
   localparam int NumDir = 27;
   localparam int PhaseBeats = 365;
   localparam int HoldCycles = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   int unsigned snd_idle_pct = 6;
   int unsigned rsp_idle_pct = 67;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   int unsigned hold_cnt = 0;
   int          errors = 0;
   int          beats_sent = 0;

   // decoder state
   logic [LeftW-1:0]  need_cont = '0;
   logic              first_cont = 1'b0;
   logic [BoundW-1:0] cont_bound = BND_FULL;
   logic              utf8_bad = 1'b0;
   logic              got_nul = 1'b0;
   logic              got_byte = 1'b0;

   verdict_type expected_verdicts[$];

   // data, present, last, required, tag; typed expectation on closing rows
   row_type dir_rows [NumDir] = '{
      '{'{8'h00, N, Y, Y, 6'd63}, Y, ST_EMPTY_REQ},
      '{'{8'hFF, N, Y, N, 6'd0},  Y, ST_OK},
      '{'{8'h00, Y, Y, N, 6'd1},  Y, ST_NUL},
      '{'{8'h7F, Y, Y, Y, 6'd2},  Y, ST_OK},
      '{'{8'h80, Y, Y, N, 6'd3},  Y, ST_BAD_UTF8},
      '{'{8'hFF, Y, Y, N, 6'd4},  Y, ST_BAD_UTF8},
      '{'{8'hC1, Y, Y, N, 6'd5},  Y, ST_BAD_UTF8},
      '{'{8'hC2, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'hBF, Y, Y, N, 6'd7},  Y, ST_OK},
      '{'{8'hE0, Y, N, Y, 6'd63}, N, ST_OK},
      '{'{8'hA0, Y, Y, N, 6'd8},  Y, ST_BAD_UTF8},
      '{'{8'hED, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'hA0, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'h80, Y, Y, N, 6'd9},  Y, ST_BAD_UTF8},
      '{'{8'hF0, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'h90, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'h80, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'h80, Y, Y, N, 6'd10}, Y, ST_OK},
      '{'{8'hF4, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'h90, Y, Y, N, 6'd11}, Y, ST_BAD_UTF8},
      '{'{8'hFF, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'h00, Y, Y, N, 6'd12}, Y, ST_NUL},
      '{'{8'hC3, Y, N, N, 6'd0},  N, ST_OK},
      '{'{8'hFF, N, N, Y, 6'd63}, N, ST_OK},
      '{'{8'hA9, Y, Y, N, 6'd13}, N, ST_OK},
      '{'{8'h00, N, N, N, 6'd0},  N, ST_OK},
      '{'{8'h00, N, Y, Y, 6'd62}, Y, ST_EMPTY_REQ}
   };

   utf8_string_checker_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte, [13:8] field_tag, [15:14] zero
      .req_tuser  (req_tuser),   // [0] byte_present, [1] required
      .req_tlast  (req_tlast),   // last_of_string
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [1:0] status, [7:2] tag_out
   );

   always #5 clock = ~clock;

   task automatic decode_beat(input beat_type b, output logic [StatusW-1:0] st);
      logic [ByteW-1:0] lo;
      logic [ByteW-1:0] hi;
      st = ST_OK;
      if (b.present) begin
         got_byte = 1'b1;
         if (b.data == 8'h00) got_nul = 1'b1;
         if (need_cont == 0) begin
            if (b.data >= Lead2Lo && b.data <= Lead2Hi) begin
               need_cont = 2'd1;
               cont_bound = BND_FULL;
               first_cont = 1'b1;
            end else if (b.data >= Lead3Lo && b.data <= Lead3Hi) begin
               need_cont = 2'd2;
               cont_bound = (b.data == Lead3Lo) ? BND_A0_BF :
                            (b.data == Lead3Sur) ? BND_80_9F : BND_FULL;
               first_cont = 1'b1;
            end else if (b.data >= Lead4Lo && b.data <= Lead4Hi) begin
               need_cont = 2'd3;
               cont_bound = (b.data == Lead4Lo) ? BND_90_BF :
                            (b.data == Lead4Hi) ? BND_80_8F : BND_FULL;
               first_cont = 1'b1;
            end else if (b.data >= ContLo) begin
               utf8_bad = 1'b1;
            end
         end else begin
            lo = ContLo;
            hi = ContHi;
            if (first_cont) begin
               case (cont_bound)
                  BND_A0_BF: lo = FirstA0;
                  BND_80_9F: hi = First9F;
                  BND_90_BF: lo = First90;
                  BND_80_8F: hi = First8F;
                  default: ;
               endcase
            end
            if (b.data < lo || b.data > hi) begin
               // drop the sequence, next byte is taken as a lead
               utf8_bad = 1'b1;
               need_cont = '0;
               first_cont = 1'b0;
               cont_bound = BND_FULL;
            end else begin
               need_cont = need_cont - 2'd1;
               first_cont = 1'b0;
               if (need_cont == 0) cont_bound = BND_FULL;
            end
         end
      end
      if (b.last) begin
         if (need_cont != 0) utf8_bad = 1'b1;
         if (b.required && !got_byte) st = ST_EMPTY_REQ;
         else if (got_nul)            st = ST_NUL;
         else if (utf8_bad)           st = ST_BAD_UTF8;
         need_cont = '0;
         first_cont = 1'b0;
         cont_bound = BND_FULL;
         utf8_bad = 1'b0;
         got_nul = 1'b0;
         got_byte = 1'b0;
      end
   endtask

   task automatic send_beat(input beat_type b, input logic typed,
                            input logic [StatusW-1:0] typed_st);
      logic [StatusW-1:0] st;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, b.tag, b.data};
      req_tuser  <= {b.required, b.present};
      req_tlast  <= b.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_beat(b, st);
      if (b.last)
         expected_verdicts.insert(expected_verdicts.size(),
                                  verdict_type'{typed ? typed_st : st, b.tag});
      beats_sent++;
   endtask

   function automatic logic [ByteW-1:0] rand_byte(input logic [ByteW-1:0] lo,
                                                  input logic [ByteW-1:0] hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   // appends one well-formed scalar value
   function automatic void add_scalar(ref logic [ByteW-1:0] s[$]);
      logic [ByteW-1:0] lead;
      case ($urandom_range(3))
         0: s.insert(s.size(), rand_byte(8'h01, 8'h7F));
         1: begin
            s.insert(s.size(), rand_byte(Lead2Lo, Lead2Hi));
            s.insert(s.size(), rand_byte(ContLo, ContHi));
         end
         2: begin
            lead = rand_byte(Lead3Lo, Lead3Hi);
            s.insert(s.size(), lead);
            if (lead == Lead3Lo)       s.insert(s.size(), rand_byte(FirstA0, ContHi));
            else if (lead == Lead3Sur) s.insert(s.size(), rand_byte(ContLo, First9F));
            else                       s.insert(s.size(), rand_byte(ContLo, ContHi));
            s.insert(s.size(), rand_byte(ContLo, ContHi));
         end
         default: begin
            lead = rand_byte(Lead4Lo, Lead4Hi);
            s.insert(s.size(), lead);
            if (lead == Lead4Lo)      s.insert(s.size(), rand_byte(First90, ContHi));
            else if (lead == Lead4Hi) s.insert(s.size(), rand_byte(ContLo, First8F));
            else                      s.insert(s.size(), rand_byte(ContLo, ContHi));
            s.insert(s.size(), rand_byte(ContLo, ContHi));
            s.insert(s.size(), rand_byte(ContLo, ContHi));
         end
      endcase
   endfunction

   task automatic send_random_string();
      logic [ByteW-1:0] s[$];
      int unsigned kind;
      int unsigned pos;
      logic close_empty;
      logic is_last;
      kind = $urandom_range(99);
      repeat ($urandom_range(5)) add_scalar(s);
      if (kind < 10) begin
         s.delete();
         repeat ($urandom_range(6)) s.insert(s.size(), 8'($urandom_range(255)));
      end else if (kind < 28 && s.size() > 0) begin
         pos = $urandom_range(s.size() - 1);
         case ($urandom_range(2))
            0: s[pos] = 8'($urandom_range(255));
            1: s.delete(s.size() - 1);
            default: s.insert(pos, rand_byte(ContLo, ContHi));
         endcase
      end else if (kind < 33) begin
         pos = $urandom_range(s.size());
         s.insert(pos, 8'h00);
      end
      close_empty = (s.size() == 0) || ($urandom_range(9) == 0);
      for (int i = 0; i < s.size(); i++) begin
         if ($urandom_range(19) == 0)
            send_beat('{8'($urandom_range(255)), N, N, 1'($urandom_range(1)),
                        6'($urandom_range(63))}, N, ST_OK);
         is_last = (i == s.size() - 1) && !close_empty;
         send_beat('{s[i], Y, is_last, 1'($urandom_range(1)), 6'($urandom_range(63))},
                   N, ST_OK);
      end
      if (close_empty)
         send_beat('{8'($urandom_range(255)), N, Y, 1'($urandom_range(1)),
                     6'($urandom_range(63))}, N, ST_OK);
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cnt != 0) begin
            rsp_tready <= 1'b0;
            hold_cnt = hold_cnt - 1;
         end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt = HoldCycles;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            $error("result beat with no string pending: tdata %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_tdata[1:0] != want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[7:2] != want.tag) begin
               $error("tag_out: expected %0d, actual %0d", want.tag, rsp_tdata[7:2]);
               errors++;
            end
         end
      end
   end

   initial begin
      int unsigned waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NumDir; i++)
         send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].st);
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin snd_idle_pct = 6;  rsp_idle_pct = 67; end
            1: begin snd_idle_pct = 67; rsp_idle_pct = 6;  end
            default: begin
               snd_idle_pct = 0;
               rsp_idle_pct = 0;
               hold_go <= 1'b1;
            end
         endcase
         beats_sent = 0;
         while (beats_sent < PhaseBeats) send_random_string();
      end
      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_verdicts.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_verdicts.size() != 0) begin
         $error("%0d results never arrived", expected_verdicts.size());
         errors++;
      end
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
